FILE: hw/rtl/dnc_pkg.sv
// Package with the shared types and constants of the DNS name checker.
`default_nettype none
package dnc_pkg;

  localparam logic [7:0] CHAR_DOT    = 8'h2e;
  localparam logic [7:0] CHAR_STAR   = 8'h2a;
  localparam logic [7:0] CHAR_HYPHEN = 8'h2d;
  localparam logic [7:0] CHAR_UP_A   = 8'h41;
  localparam logic [7:0] CHAR_UP_Z   = 8'h5a;
  localparam logic [7:0] CHAR_LO_A   = 8'h61;
  localparam logic [7:0] CHAR_LO_Z   = 8'h7a;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CASE_OFFSET = CHAR_LO_A - CHAR_UP_A;

  localparam int unsigned MIN_WILDCARD_LEN = 5;
  localparam int unsigned QUEUE_DEPTH      = 2;

  typedef enum logic [1:0] {
    POS_FIRST,
    POS_SECOND,
    POS_BODY
  } pos_e;

  // One classified byte as it travels from the front to the back.
  typedef struct packed {
    logic [7:0] lower;
    logic       is_dot;
    logic       byte_ok;
    logic       wild;
    logic       prefix;
    logic       prefix_bad;
    logic       last;
  } class_t;

endpackage
`default_nettype wire

FILE: hw/rtl/dnc_stream_if.sv
// Stream interfaces for the byte input and the result output.
`default_nettype none
interface dnc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       wildcard_name;
  logic       last_char;

  modport source (output valid, output char_in, output wildcard_name, output last_char,
                  input ready);
  modport sink (input valid, input char_in, input wildcard_name, input last_char,
                output ready);
endinterface

interface dnc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] lower_char;
  logic       name_done;
  logic       name_valid;

  modport source (output valid, output lower_char, output name_done, output name_valid,
                  input ready);
  modport sink (input valid, input lower_char, input name_done, input name_valid,
                output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/dns_name_checker.sv
// Top level of the DNS name checker: front end, queue and back end.
// The checker takes one byte of a host name per transaction and returns one result per
// byte: the byte folded to lower case, plus the verdict on the final byte. It sustains
// one byte per clock cycle while the receiver keeps taking results; the length and label
// counters in the back end update as each byte is taken. A byte's result passes through
// the two-entry queue and then the result register, and input stays open while a result
// waits to be taken until the queue fills.
`default_nettype none
module dns_name_checker #(
  parameter int unsigned MAX_NAME_LEN  = 253,
  parameter int unsigned MAX_LABEL_LEN = 63
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dnc_in_if.sink    in_i,
  dnc_out_if.source out_o
);

  dnc_pkg::class_t push_item;
  dnc_pkg::class_t pop_item;
  logic            push, pop, full, empty;

  dnc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (full),
    .q_push_o (push),
    .q_item_o (push_item)
  );

  dnc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_item_o  (pop_item)
  );

  dnc_back #(
    .MAX_NAME_LEN  (MAX_NAME_LEN),
    .MAX_LABEL_LEN (MAX_LABEL_LEN)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (empty),
    .q_item_i  (pop_item),
    .q_pop_o   (pop),
    .out_o     (out_o)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/dnc_front.sv
// Front end: accepts bytes, tracks the position in the name and classifies each byte.
`default_nettype none
module dnc_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  dnc_in_if.sink               in_i,
  input  wire logic            q_full_i,
  output logic                 q_push_o,
  output dnc_pkg::class_t      q_item_o
);

  dnc_pkg::pos_e pos_q, pos_d;
  logic          wild_q, wild_d;
  logic          accept;
  logic          wild;
  logic [7:0]    c;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && !q_full_i;
  assign q_push_o   = accept;
  assign c          = in_i.char_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= dnc_pkg::POS_FIRST;
      wild_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      wild_q <= wild_d;
    end
  end

  always_comb begin
    pos_d  = pos_q;
    wild_d = wild_q;
    wild   = (pos_q == dnc_pkg::POS_FIRST) ? in_i.wildcard_name : wild_q;
    if (accept) begin
      wild_d = wild;
      if (in_i.last_char) begin
        pos_d = dnc_pkg::POS_FIRST;
      end else begin
        case (pos_q)
          dnc_pkg::POS_FIRST:  pos_d = dnc_pkg::POS_SECOND;
          dnc_pkg::POS_SECOND: pos_d = dnc_pkg::POS_BODY;
          dnc_pkg::POS_BODY:   pos_d = dnc_pkg::POS_BODY;
          default:             pos_d = dnc_pkg::POS_FIRST;
        endcase
      end
    end
  end

  always_comb begin
    q_item_o.lower = (c >= dnc_pkg::CHAR_UP_A && c <= dnc_pkg::CHAR_UP_Z) ?
                     c + dnc_pkg::CASE_OFFSET : c;
    q_item_o.is_dot  = (c == dnc_pkg::CHAR_DOT);
    q_item_o.byte_ok = (c >= dnc_pkg::CHAR_LO_A && c <= dnc_pkg::CHAR_LO_Z) ||
                       (c >= dnc_pkg::CHAR_UP_A && c <= dnc_pkg::CHAR_UP_Z) ||
                       (c >= dnc_pkg::CHAR_ZERO && c <= dnc_pkg::CHAR_NINE) ||
                       (c == dnc_pkg::CHAR_HYPHEN);
    q_item_o.wild    = wild;
    q_item_o.prefix  = wild && (pos_q != dnc_pkg::POS_BODY);
    // The first byte of a wildcard name must be a star and the second a dot.
    q_item_o.prefix_bad = (pos_q == dnc_pkg::POS_FIRST) ? (c != dnc_pkg::CHAR_STAR)
                                                        : (c != dnc_pkg::CHAR_DOT);
    q_item_o.last    = in_i.last_char;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/dnc_queue.sv
// Short queue of classified bytes between the front end and the back end.
`default_nettype none
module dnc_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire dnc_pkg::class_t push_item_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output dnc_pkg::class_t      pop_item_o
);

  localparam int unsigned PW = (dnc_pkg::QUEUE_DEPTH > 1) ? $clog2(dnc_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(dnc_pkg::QUEUE_DEPTH + 1);

  dnc_pkg::class_t mem_q [dnc_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;
  logic            do_push, do_pop;

  assign full_o     = (count_q == CW'(dnc_pkg::QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(dnc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(dnc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/dnc_back.sv
// Back end: per-name counters, rule checks and the registered result stage.
`default_nettype none
module dnc_back #(
  parameter int unsigned MAX_NAME_LEN  = 253,
  parameter int unsigned MAX_LABEL_LEN = 63
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_empty_i,
  input  wire dnc_pkg::class_t q_item_i,
  output logic                 q_pop_o,
  dnc_out_if.source            out_o
);

  localparam int unsigned TW = $clog2(MAX_NAME_LEN + 2);
  localparam int unsigned LW = $clog2(MAX_LABEL_LEN + 2);

  logic [TW-1:0] total_q, total_d;
  logic [LW-1:0] label_q, label_d;
  logic          fail_q, fail_d;
  logic          suffix_q, suffix_d;
  logic          verdict;
  logic          out_valid_q;
  logic [7:0]    out_char_q;
  logic          out_done_q, out_verdict_q;
  logic          take;

  // The result register takes a new transaction when it is empty or being drained.
  assign take    = !q_empty_i && (!out_valid_q || out_o.ready);
  assign q_pop_o = take;

  always_comb begin
    total_d  = total_q;
    label_d  = label_q;
    fail_d   = fail_q;
    suffix_d = suffix_q;
    verdict  = 1'b0;

    if (q_item_i.prefix) begin
      if (q_item_i.prefix_bad) begin
        fail_d = 1'b1;
      end
    end else if (q_item_i.is_dot) begin
      if (q_item_i.wild) begin
        suffix_d = 1'b1;
      end
      if (label_q == '0 || label_q > LW'(MAX_LABEL_LEN)) begin
        fail_d = 1'b1;
      end
      label_d = '0;
    end else begin
      if (!q_item_i.byte_ok) begin
        fail_d = 1'b1;
      end
      if (label_q <= LW'(MAX_LABEL_LEN)) begin
        label_d = label_q + 1'b1;
      end
    end

    if (total_q <= TW'(MAX_NAME_LEN)) begin
      total_d = total_q + 1'b1;
    end

    if (q_item_i.last) begin
      verdict = !fail_d && total_d != '0 && total_d <= TW'(MAX_NAME_LEN) &&
                !q_item_i.is_dot && label_d != '0 && label_d <= LW'(MAX_LABEL_LEN) &&
                (!q_item_i.wild ||
                 (total_d >= TW'(dnc_pkg::MIN_WILDCARD_LEN) && suffix_d));
      total_d  = '0;
      label_d  = '0;
      fail_d   = 1'b0;
      suffix_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      label_q     <= '0;
      fail_q      <= 1'b0;
      suffix_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        total_q  <= total_d;
        label_q  <= label_d;
        fail_q   <= fail_d;
        suffix_q <= suffix_d;
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_char_q    <= q_item_i.lower;
      out_done_q    <= q_item_i.last;
      out_verdict_q <= verdict;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.lower_char = out_char_q;
  assign out_o.name_done  = out_done_q;
  assign out_o.name_valid = out_verdict_q;

  a_total_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TW'(MAX_NAME_LEN + 1))
    else $error("total count above its saturation value");

  a_label_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    label_q <= LW'(MAX_LABEL_LEN + 1))
    else $error("label count above its saturation value");

  a_clear_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && q_item_i.last) |=> (total_q == '0 && label_q == '0 && !fail_q && !suffix_q))
    else $error("per-name state not cleared after the final byte");

  a_verdict_only_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_done_q) |-> !out_verdict_q)
    else $error("verdict raised on a byte that is not the final one");

endmodule
`default_nettype wire

FILE: test/tb.sv
// Self-checking testbench for the DNS name checker with a built-in predictor.
`timescale 1ns / 100ps
module tb;

  localparam int unsigned NAME_MAX  = 253;
  localparam int unsigned LABEL_MAX = 63;

  typedef struct packed {
    logic [7:0] ch;
    logic       wc;
    logic       last;
  } name_byte_t;

  typedef struct packed {
    logic [7:0] lower;
    logic       done;
    logic       ok;
  } folded_t;

  typedef enum int {
    FLIP_BYTE,
    LEAD_DOT,
    TRAIL_DOT,
    DOUBLE_DOT,
    STRAY_STAR,
    FLAG_FLIP
  } damage_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  dnc_in_if  in_if ();
  dnc_out_if out_if ();

  dns_name_checker #(
    .MAX_NAME_LEN (NAME_MAX),
    .MAX_LABEL_LEN(LABEL_MAX)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #5 clk_i = ~clk_i;

  name_byte_t name_bytes_q[$];
  folded_t    folded_q[$];
  logic [7:0] byte_buf[$];

  int src_idle_pct;
  int snk_stall_pct;
  int error_cnt;
  int names_sent;
  int wild_names;
  int bytes_queued;
  int bytes_seen;
  int valid_verdicts;

  // Per-name state of the predictor.
  logic [7:0] total_cnt   = '0;
  logic [6:0] label_cnt   = '0;
  logic       name_failed = 1'b0;
  logic       wild_lat    = 1'b0;
  logic       suffix_dot  = 1'b0;
  logic       after_dot   = 1'b0;

  function automatic folded_t check_name_byte(logic [7:0] c, logic wc, logic last);
    folded_t    res;
    logic [7:0] pos;
    logic       host_ok;
    pos = total_cnt;
    host_ok = (c >= dnc_pkg::CHAR_LO_A && c <= dnc_pkg::CHAR_LO_Z) ||
              (c >= dnc_pkg::CHAR_UP_A && c <= dnc_pkg::CHAR_UP_Z) ||
              (c >= dnc_pkg::CHAR_ZERO && c <= dnc_pkg::CHAR_NINE) ||
              c == dnc_pkg::CHAR_HYPHEN;
    if (pos == 0) wild_lat = wc;
    if (wild_lat && pos < 2) begin
      // The wildcard prefix must read "*." exactly.
      if (pos == 0 && c != dnc_pkg::CHAR_STAR) name_failed = 1'b1;
      if (pos == 1 && c != dnc_pkg::CHAR_DOT) name_failed = 1'b1;
      after_dot = (c == dnc_pkg::CHAR_DOT);
    end else if (c == dnc_pkg::CHAR_DOT) begin
      if (wild_lat) suffix_dot = 1'b1;
      if (label_cnt == 0 || label_cnt > LABEL_MAX) name_failed = 1'b1;
      label_cnt = '0;
      after_dot = 1'b1;
    end else begin
      if (!host_ok) name_failed = 1'b1;
      if (label_cnt <= LABEL_MAX) label_cnt = label_cnt + 7'd1;
      after_dot = 1'b0;
    end
    if (total_cnt <= NAME_MAX) total_cnt = total_cnt + 8'd1;
    res.lower = (c >= dnc_pkg::CHAR_UP_A && c <= dnc_pkg::CHAR_UP_Z) ?
                c + dnc_pkg::CASE_OFFSET : c;
    res.done  = last;
    res.ok    = 1'b0;
    if (last) begin
      res.ok = !name_failed && total_cnt >= 1 && total_cnt <= NAME_MAX &&
               c != dnc_pkg::CHAR_DOT && label_cnt >= 1 && label_cnt <= LABEL_MAX;
      if (wild_lat) begin
        res.ok = res.ok && total_cnt >= dnc_pkg::MIN_WILDCARD_LEN && suffix_dot;
      end
      total_cnt   = '0;
      label_cnt   = '0;
      name_failed = 1'b0;
      wild_lat    = 1'b0;
      suffix_dot  = 1'b0;
      after_dot   = 1'b0;
    end
    return res;
  endfunction

  function automatic logic [7:0] host_char();
    int r;
    r = $urandom_range(9);
    if (r == 0) return dnc_pkg::CHAR_HYPHEN;
    if (r < 3) return dnc_pkg::CHAR_ZERO + 8'($urandom_range(9));
    if (r < 6) return dnc_pkg::CHAR_UP_A + 8'($urandom_range(25));
    return dnc_pkg::CHAR_LO_A + 8'($urandom_range(25));
  endfunction

  task automatic append_byte(logic [7:0] b);
    byte_buf = {byte_buf, b};
  endtask

  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++) append_byte(s[i]);
  endtask

  task automatic put_label(int len);
    for (int i = 0; i < len; i++) append_byte(host_char());
  endtask

  // Moves the assembled name into the send queue; the wildcard flag only
  // matters on the first byte, so later bytes carry a random flag.
  task automatic flush_name(logic wc);
    name_byte_t item;
    for (int i = 0; i < byte_buf.size(); i++) begin
      item.ch   = byte_buf[i];
      item.wc   = (i == 0) ? wc : 1'($urandom_range(1));
      item.last = (i == byte_buf.size() - 1);
      name_bytes_q = {name_bytes_q, item};
    end
    bytes_queued += byte_buf.size();
    names_sent++;
    if (wc) wild_names++;
    byte_buf.delete();
  endtask

  task automatic wait_drained();
    while (name_bytes_q.size() != 0 || in_if.valid || folded_q.size() != 0) @(posedge clk_i);
  endtask

  // Driver: presents the next byte and runs the predictor on every accepted transaction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid         <= 1'b0;
      in_if.char_in       <= '0;
      in_if.wildcard_name <= 1'b0;
      in_if.last_char     <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        folded_q = {folded_q, check_name_byte(in_if.char_in, in_if.wildcard_name,
                                              in_if.last_char)};
      end
      if (!in_if.valid || in_if.ready) begin
        if (name_bytes_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          name_byte_t item;
          item = name_bytes_q.pop_front();
          in_if.valid         <= 1'b1;
          in_if.char_in       <= item.ch;
          in_if.wildcard_name <= item.wc;
          in_if.last_char     <= item.last;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure and field-by-field comparison.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
      if (out_if.valid && out_if.ready) begin
        bytes_seen++;
        if (folded_q.size() == 0) begin
          $error("unexpected result: lower_char=%h name_done=%b name_valid=%b",
                 out_if.lower_char, out_if.name_done, out_if.name_valid);
          error_cnt++;
        end else begin
          folded_t want;
          want = folded_q.pop_front();
          if (out_if.lower_char !== want.lower) begin
            $error("lower_char: expected %h, got %h", want.lower, out_if.lower_char);
            error_cnt++;
          end
          if (out_if.name_done !== want.done) begin
            $error("name_done: expected %b, got %b", want.done, out_if.name_done);
            error_cnt++;
          end
          if (out_if.name_valid !== want.ok) begin
            $error("name_valid: expected %b, got %b", want.ok, out_if.name_valid);
            error_cnt++;
          end
          if (want.done && want.ok) valid_verdicts++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int src_pcts[4];
    int snk_pcts[4];
    int target;
    int kind;
    int nlab;
    int pos;
    int len;
    logic wc;
    logic long_name;
    logic [7:0] odd_bytes[8];

    src_pcts = '{0, 49, 0, 15};
    snk_pcts = '{0, 0, 49, 15};
    odd_bytes = '{8'h00, 8'hff, 8'h40, 8'h5b, 8'h60, 8'h7b, 8'h2f, 8'h3a};
    src_idle_pct = 0;
    snk_stall_pct = 0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed names: edge characters, dot placement, wildcard prefix and length limits.
    put_str("a");          flush_name(1'b0);
    put_str(".");          flush_name(1'b0);
    put_str(".ab");        flush_name(1'b0);
    put_str("ab.");        flush_name(1'b0);
    put_str("a..b");       flush_name(1'b0);
    put_str("AZaz09-.Zz"); flush_name(1'b0);
    put_str("a*b.c");      flush_name(1'b0);
    put_str("*.A.b");      flush_name(1'b1);
    put_str("*.ab");       flush_name(1'b1);
    put_str("*.abc");      flush_name(1'b1);
    put_str("x.a.b");      flush_name(1'b1);
    put_str("*-a.b");      flush_name(1'b1);
    put_str("*");          flush_name(1'b1);
    put_str("*.");         flush_name(1'b1);
    put_str("*.*.b");      flush_name(1'b1);
    // Exactly the longest legal name, built mostly from labels of the longest legal length.
    put_label(63); put_str("."); put_label(63); put_str("."); put_label(63); put_str(".");
    put_label(61); flush_name(1'b0);
    // An overlong name that opens with an overlong label; both counters saturate here.
    put_label(66); put_str("."); put_label(63); put_str("."); put_label(63); put_str(".");
    put_label(61); flush_name(1'b0);
    foreach (odd_bytes[i]) begin
      append_byte(odd_bytes[i]);
      flush_name(1'($urandom_range(1)));
    end

    for (int p = 0; p < 4; p++) begin
      src_idle_pct = src_pcts[p];
      snk_stall_pct = snk_pcts[p];
      target = bytes_queued + 25;
      while (bytes_queued < target) begin
        kind = $urandom_range(99);
        if (kind < 72) begin
          wc = ($urandom_range(2) == 0);
          if (wc) put_str("*.");
          long_name = ($urandom_range(49) == 0);
          nlab = long_name ? $urandom_range(3, 4) : $urandom_range(1, 4);
          for (int k = 0; k < nlab; k++) begin
            if (k != 0) append_byte(dnc_pkg::CHAR_DOT);
            if (long_name) put_label($urandom_range(40, 66));
            else if ($urandom_range(29) == 0) put_label($urandom_range(60, 66));
            else put_label($urandom_range(1, 10));
          end
          if ($urandom_range(3) == 0) begin
            pos = $urandom_range(byte_buf.size() - 1);
            case (damage_e'($urandom_range(5)))
              FLIP_BYTE: begin
                byte_buf[pos] = 8'($urandom);
              end
              LEAD_DOT: begin
                byte_buf.push_front(dnc_pkg::CHAR_DOT);
              end
              TRAIL_DOT: begin
                append_byte(dnc_pkg::CHAR_DOT);
              end
              DOUBLE_DOT: begin
                byte_buf.insert(pos, dnc_pkg::CHAR_DOT);
                byte_buf.insert(pos, dnc_pkg::CHAR_DOT);
              end
              STRAY_STAR: begin
                byte_buf.insert(pos, dnc_pkg::CHAR_STAR);
              end
              default: begin
                wc = !wc;
              end
            endcase
          end
        end else begin
          wc = 1'($urandom_range(1));
          len = $urandom_range(1, 12);
          for (int k = 0; k < len; k++) begin
            case ($urandom_range(3))
              0: append_byte(8'($urandom));
              1: append_byte(dnc_pkg::CHAR_DOT);
              default: append_byte(host_char());
            endcase
          end
          if (wc && $urandom_range(1)) byte_buf[0] = dnc_pkg::CHAR_STAR;
        end
        flush_name(wc);
      end
      // The sender holds off here until every result of this phase is back.
      wait_drained();
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("Checked %0d host names (%0d wildcard, %0d judged valid) in %0d results.",
             names_sent, wild_names, valid_verdicts, bytes_seen);
    $display("Ran with no idling, a slow sender, a slow receiver and both; %0d mismatches.",
             error_cnt);
    if (error_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
